[hdl/dtrm_pkg.sv]
// Shared constants, item types, bit-length and rounding helpers for the direction-to-rotation block.
`default_nettype none

package dtrm_pkg;

  localparam int IN_W        = 32;
  localparam int OUT_FRAC    = 14;
  localparam int OUT_W       = OUT_FRAC + 2;
  localparam int QB          = 30;
  localparam int NORM_TOP    = 31;
  localparam int MAG_W       = IN_W;
  localparam int NM_W        = NORM_TOP;
  localparam int SQR_W       = 2 * NM_W;
  localparam int SQ_W        = SQR_W + 2;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int NUM_W       = ROOT_W;
  localparam int DEN_W       = ROOT_W;
  localparam int Q_W         = QB + 1;
  localparam int QV_W        = Q_W + 1;
  localparam int PROD_W      = 2 * QV_W;
  localparam int S1          = QB - OUT_FRAC;
  localparam int SP          = 2 * QB - OUT_FRAC;
  localparam int BLEN_W      = $clog2(MAG_W + 1);
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W;
  localparam int BACK_STAGES = 3 + SQRT_STAGES + DIV_STAGES + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1 << OUT_FRAC);
  localparam logic signed [QV_W-1:0]  ONE_Q   = QV_W'(1 << QB);

  typedef struct packed {
    logic [NM_W-1:0] mx;
    logic [NM_W-1:0] my;
    logic [NM_W-1:0] mz;
    logic            nx;
    logic            ny;
    logic            nz;
    logic            zero;
  } norm_t;

  function automatic logic [BLEN_W-1:0] bitlen(input logic [MAG_W-1:0] m);
    logic [BLEN_W-1:0] b;
    b = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        b = BLEN_W'(i + 1);
      end
    end
    return b;
  endfunction

  function automatic logic [OUT_W-1:0] outq_s(input logic signed [QV_W-1:0] v);
    logic            neg;
    logic [QV_W-1:0] mag;
    logic [QV_W-1:0] rnd;
    logic [OUT_W-1:0] res;
    neg = v[QV_W-1];
    mag = neg ? QV_W'(-v) : QV_W'(v);
    rnd = (mag + QV_W'(1 << (S1 - 1))) >> S1;
    if (rnd > QV_W'(ONE_OUT)) begin
      rnd = QV_W'(ONE_OUT);
    end
    res = rnd[OUT_W-1:0];
    return neg ? OUT_W'(-res) : res;
  endfunction

  function automatic logic [OUT_W-1:0] outq_p(input logic signed [PROD_W-1:0] v);
    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [OUT_W-1:0]  res;
    neg = v[PROD_W-1];
    mag = neg ? PROD_W'(-v) : PROD_W'(v);
    rnd = (mag + (PROD_W'(1) << (SP - 1))) >> SP;
    if (rnd > PROD_W'(ONE_OUT)) begin
      rnd = PROD_W'(ONE_OUT);
    end
    res = rnd[OUT_W-1:0];
    return neg ? OUT_W'(-res) : res;
  endfunction

endpackage

`default_nettype wire

[hdl/dtrm_front.sv]
// Front end: accepts vectors, takes magnitudes and normalizes them for the queue.
`default_nettype none

module dtrm_front import dtrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  vx,
  input  logic signed [IN_W-1:0]  vy,
  input  logic signed [IN_W-1:0]  vz,
  output logic                    push,
  input  logic                    full,
  output norm_t                   push_data
);

  logic             f_valid;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [MAG_W-1:0] mag_z;
  logic             neg_x;
  logic             neg_y;
  logic             neg_z;
  logic             fen;
  logic [BLEN_W-1:0] b;

  function automatic logic [NM_W-1:0] norm(input logic [MAG_W-1:0] m,
                                           input logic [BLEN_W-1:0] bl);
    logic [MAG_W-1:0] t;
    if (int'(bl) < NORM_TOP) begin
      t = m << (NORM_TOP - int'(bl));
    end else begin
      t = m >> (int'(bl) - NORM_TOP);
    end
    return t[NM_W-1:0];
  endfunction

  assign fen      = !f_valid || !full;
  assign in_stall = !fen;
  assign push     = f_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (fen) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fen && in_valid) begin
      neg_x <= vx[IN_W-1];
      neg_y <= vy[IN_W-1];
      neg_z <= vz[IN_W-1];
      mag_x <= vx[IN_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
      mag_y <= vy[IN_W-1] ? MAG_W'(-vy) : MAG_W'(vy);
      mag_z <= vz[IN_W-1] ? MAG_W'(-vz) : MAG_W'(vz);
    end
  end

  always_comb begin
    b              = bitlen(mag_x | mag_y | mag_z);
    push_data.mx   = norm(mag_x, b);
    push_data.my   = norm(mag_y, b);
    push_data.mz   = norm(mag_z, b);
    push_data.nx   = neg_x;
    push_data.ny   = neg_y;
    push_data.nz   = neg_z;
    push_data.zero = (b == '0);
  end

endmodule

`default_nettype wire

[hdl/dtrm_queue.sv]
// Short queue between the front end and the arithmetic back end.
`default_nettype none

module dtrm_queue import dtrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  norm_t push_data,
  output logic  full,
  input  logic  pop,
  output norm_t head,
  output logic  nonempty
);

  norm_t           mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wp;
  logic [QA_W-1:0] rp;
  logic [QA_W:0]   cnt;

  assign full     = (cnt == (QA_W+1)'(QUEUE_DEPTH));
  assign nonempty = (cnt != '0);
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/dtrm_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module dtrm_sqrt import dtrm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   n,
  output logic [ROOT_W-1:0] root
);

  localparam int TW = SQ_W + 2;

  logic [SQ_W-1:0]   rem_q  [SQRT_STAGES-1];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - i;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TW-1:0]     trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in  = n;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[i] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
      end
    end

    if (i < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? (rem_in - trial[SQ_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

[hdl/dtrm_div.sv]
// Pipelined restoring divider giving a Q30 ratio rounded half up.
`default_nettype none

module dtrm_div import dtrm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] a,
  input  logic [DEN_W-1:0] d,
  output logic [Q_W-1:0]   q
);

  localparam int RW = NUM_W + QB + 1;

  logic [RW-1:0]    rem_q [DIV_STAGES-1];
  logic [DEN_W-1:0] den_q [DIV_STAGES-1];
  logic [Q_W-1:0]   q_q   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - i;
    logic [RW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [RW:0]      dv;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = (RW'(a) << QB) + RW'(d >> 1);
      assign den_in = d;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign q_in   = q_q[i-1];
    end

    assign dv   = (RW+1)'(den_in) << K;
    assign take = (RW+1)'(rem_in) >= dv;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[i] <= take ? (q_in | (Q_W'(1) << K)) : q_in;
      end
    end

    if (i < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? (rem_in - dv[RW-1:0]) : rem_in;
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign q = q_q[DIV_STAGES-1];

endmodule

`default_nettype wire

[hdl/dtrm_back.sv]
// Back end: squares, roots, ratios, products and output rounding in one pipeline.
`default_nettype none

module dtrm_back import dtrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  norm_t                   head,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] r00,
  output logic signed [OUT_W-1:0] r01,
  output logic signed [OUT_W-1:0] r02,
  output logic signed [OUT_W-1:0] r10,
  output logic signed [OUT_W-1:0] r11,
  output logic signed [OUT_W-1:0] r12,
  output logic signed [OUT_W-1:0] r20,
  output logic signed [OUT_W-1:0] r21,
  output logic signed [OUT_W-1:0] r22,
  output logic                    zero_vector
);

  typedef struct packed {
    logic nx;
    logic ny;
    logic nz;
    logic zero;
    logic ydir;
  } flag_t;

  typedef struct packed {
    logic [NM_W-1:0] my;
    logic [NM_W-1:0] ax;
    logic [NM_W-1:0] az;
    flag_t           flg;
  } side_t;

  logic                   en;
  logic [BACK_STAGES-1:0] vld;

  logic [BLEN_W-1:0] bxz;
  logic [NM_W-1:0]   ax_c;
  logic [NM_W-1:0]   az_c;
  flag_t             flg_c;

  logic [SQR_W-1:0] x2_1, y2_1, z2_1;
  side_t            sd1;
  logic [SQ_W-1:0]  s2_2, r2_2;
  logic [SQR_W-1:0] ax2_2, az2_2;
  side_t            sd2;
  logic [SQ_W-1:0]  s2_3, r2_3, rr2_3;
  side_t            sd3;

  side_t sd [SQRT_STAGES];
  flag_t fd [DIV_STAGES];

  logic [ROOT_W-1:0] l_root, r_root, rr_root;
  logic [Q_W-1:0]    q_cv, q_sv, q_ch, q_sh;
  logic signed [QV_W-1:0] cv_c, sv_c, ch_c, sh_c;

  logic signed [QV_W-1:0]   cv_p, sv_p, ch_p, sh_p;
  logic signed [PROD_W-1:0] shsv_p, shcv_p, chsv_p, chcv_p;
  logic                     zero_p;

  assign en        = !out_valid || !out_stall;
  assign pop       = en && head_valid;
  assign out_valid = vld[BACK_STAGES-1];
  assign r10       = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_STAGES-2:0], head_valid};
    end
  end

  always_comb begin
    bxz        = bitlen(MAG_W'(head.mx | head.mz));
    ax_c       = head.mx << (NORM_TOP - int'(bxz));
    az_c       = head.mz << (NORM_TOP - int'(bxz));
    flg_c.nx   = head.nx;
    flg_c.ny   = head.ny;
    flg_c.nz   = head.nz;
    flg_c.zero = head.zero;
    flg_c.ydir = (bxz == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_1    <= head.mx * head.mx;
      y2_1    <= head.my * head.my;
      z2_1    <= head.mz * head.mz;
      sd1.my  <= head.my;
      sd1.ax  <= ax_c;
      sd1.az  <= az_c;
      sd1.flg <= flg_c;

      s2_2  <= SQ_W'(x2_1) + SQ_W'(y2_1) + SQ_W'(z2_1);
      r2_2  <= SQ_W'(x2_1) + SQ_W'(z2_1);
      ax2_2 <= sd1.ax * sd1.ax;
      az2_2 <= sd1.az * sd1.az;
      sd2   <= sd1;

      s2_3  <= s2_2;
      r2_3  <= r2_2;
      rr2_3 <= SQ_W'(ax2_2) + SQ_W'(az2_2);
      sd3   <= sd2;

      sd[0] <= sd3;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sd[i] <= sd[i-1];
      end
      fd[0] <= sd[SQRT_STAGES-1].flg;
      for (int i = 1; i < DIV_STAGES; i++) begin
        fd[i] <= fd[i-1];
      end
    end
  end

  dtrm_sqrt u_sqrt_l  (.clk(clk), .en(en), .n(s2_3),  .root(l_root));
  dtrm_sqrt u_sqrt_r  (.clk(clk), .en(en), .n(r2_3),  .root(r_root));
  dtrm_sqrt u_sqrt_rr (.clk(clk), .en(en), .n(rr2_3), .root(rr_root));

  dtrm_div u_div_cv (.clk(clk), .en(en), .a(NUM_W'(sd[SQRT_STAGES-1].my)),
                     .d(l_root), .q(q_cv));
  dtrm_div u_div_sv (.clk(clk), .en(en), .a(r_root), .d(l_root), .q(q_sv));
  dtrm_div u_div_ch (.clk(clk), .en(en), .a(NUM_W'(sd[SQRT_STAGES-1].az)),
                     .d(rr_root), .q(q_ch));
  dtrm_div u_div_sh (.clk(clk), .en(en), .a(NUM_W'(sd[SQRT_STAGES-1].ax)),
                     .d(rr_root), .q(q_sh));

  always_comb begin
    cv_c = fd[DIV_STAGES-1].ny ? -$signed(QV_W'(q_cv)) : $signed(QV_W'(q_cv));
    sv_c = $signed(QV_W'(q_sv));
    if (fd[DIV_STAGES-1].ydir) begin
      ch_c = '0;
      sh_c = -ONE_Q;
    end else begin
      ch_c = fd[DIV_STAGES-1].nz ? -$signed(QV_W'(q_ch)) : $signed(QV_W'(q_ch));
      sh_c = fd[DIV_STAGES-1].nx ? -$signed(QV_W'(q_sh)) : $signed(QV_W'(q_sh));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv_p   <= cv_c;
      sv_p   <= sv_c;
      ch_p   <= ch_c;
      sh_p   <= sh_c;
      shsv_p <= sh_c * sv_c;
      shcv_p <= sh_c * cv_c;
      chsv_p <= ch_c * sv_c;
      chcv_p <= ch_c * cv_c;
      zero_p <= fd[DIV_STAGES-1].zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_vector <= zero_p;
      if (zero_p) begin
        r00 <= ONE_OUT;
        r01 <= '0;
        r02 <= '0;
        r11 <= ONE_OUT;
        r12 <= '0;
        r20 <= '0;
        r21 <= '0;
        r22 <= ONE_OUT;
      end else begin
        r00 <= outq_s(ch_p);
        r01 <= outq_p(shsv_p);
        r02 <= outq_p(shcv_p);
        r11 <= outq_s(cv_p);
        r12 <= outq_s(-sv_p);
        r20 <= outq_s(-sh_p);
        r21 <= outq_p(chsv_p);
        r22 <= outq_p(chcv_p);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/direction_to_rotation_matrix_top.sv]
// Top level: direction vector in, yaw-pitch rotation matrix out.
//
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  vx vy vz (signed Q16.16)
//  out      out_valid/ out_stall r00..r22 (signed Q1.14), zero_vector
//
//  One vector per cycle sustained while out_stall is low; the path runs through the front register,
//  the queue and the back pipeline (3 square/sum stages, 32 root stages, 31 divide stages,
//  product stage, rounding stage).
//  rst is synchronous and clears the valid bits and the queue pointers and count only.
//  out_stall with out_valid high freezes the back pipeline; the 4-entry queue then fills and in_stall rises.
`default_nettype none

module direction_to_rotation_matrix_top import dtrm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  vx,
  input  logic signed [IN_W-1:0]  vy,
  input  logic signed [IN_W-1:0]  vz,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] r00,
  output logic signed [OUT_W-1:0] r01,
  output logic signed [OUT_W-1:0] r02,
  output logic signed [OUT_W-1:0] r10,
  output logic signed [OUT_W-1:0] r11,
  output logic signed [OUT_W-1:0] r12,
  output logic signed [OUT_W-1:0] r20,
  output logic signed [OUT_W-1:0] r21,
  output logic signed [OUT_W-1:0] r22,
  output logic                    zero_vector
);

  logic  push;
  logic  full;
  norm_t push_data;
  logic  pop;
  norm_t head;
  logic  nonempty;

  dtrm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vx(vx), .vy(vy), .vz(vz),
    .push(push), .full(full), .push_data(push_data)
  );

  dtrm_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head(head), .nonempty(nonempty)
  );

  dtrm_back u_back (
    .clk(clk), .rst(rst),
    .head_valid(nonempty), .head(head), .pop(pop),
    .out_stall(out_stall), .out_valid(out_valid),
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .zero_vector(zero_vector)
  );

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> r00 == ONE_OUT && r11 == ONE_OUT && r22 == ONE_OUT
                                 && r01 == '0 && r21 == '0)
    else $error("zero vector result is not the identity");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> r11 <= ONE_OUT && r11 >= -ONE_OUT && r00 <= ONE_OUT && r00 >= -ONE_OUT)
    else $error("diagonal term outside unit range");

  a_pitch_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_vector |-> r12 <= 0)
    else $error("row 1 column 2 positive");

endmodule

`default_nettype wire

[tb/sv/direction_to_rotation_matrix_top_test.sv]
// Testbench for the direction-to-rotation block: directed and random vectors against a rotation predictor.
`timescale 1ns / 100ps
`default_nettype none

module direction_to_rotation_matrix_top_test;
  import dtrm_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] m [9];
    logic                    zero;
  } rotation_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [IN_W-1:0] vx, vy, vz;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic zero_vector;

  rotation_t pending_rotations [$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;

  direction_to_rotation_matrix_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .vx(vx), .vy(vy), .vz(vz),
    .out_valid(out_valid), .out_stall(out_stall),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22), .zero_vector(zero_vector)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int bit_length(longint unsigned m);
    int b;
    b = 0;
    while (m != 0) begin
      b++;
      m = m >> 1;
    end
    return b;
  endfunction

  function automatic longint q30_ratio(longint unsigned a, longint unsigned d, bit neg);
    longint unsigned q;
    q = ((a << QB) + (d >> 1)) / d;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [OUT_W-1:0] round_out(longint v, int s);
    longint unsigned mag;
    logic [OUT_W-1:0] res;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    if (mag > (64'd1 << OUT_FRAC)) mag = 64'd1 << OUT_FRAC;
    res = mag[OUT_W-1:0];
    return (v < 0) ? -res : res;
  endfunction

  function automatic rotation_t rotation_of(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                            logic [IN_W-1:0] z);
    rotation_t rot;
    logic [IN_W-1:0] raw [3];
    longint unsigned mg [3];
    bit ng [3];
    longint unsigned top, r2, len, rad, ax, az, rr;
    longint cv, sv, ch, sh;
    int b;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = raw[i][IN_W-1];
      mg[i] = ng[i] ? (64'd1 << IN_W) - raw[i] : 64'(raw[i]);
      if (mg[i] > top) top = mg[i];
    end
    rot.zero = 1'b0;
    if (top == 0) begin
      for (int i = 0; i < 9; i++) rot.m[i] = (i % 4 == 0) ? ONE_OUT : '0;
      rot.zero = 1'b1;
      return rot;
    end
    b = bit_length(top);
    for (int i = 0; i < 3; i++)
      mg[i] = (b < NORM_TOP) ? mg[i] << (NORM_TOP - b) : mg[i] >> (b - NORM_TOP);
    r2 = mg[0] * mg[0] + mg[2] * mg[2];
    len = int_sqrt(r2 + mg[1] * mg[1]);
    rad = int_sqrt(r2);
    cv = q30_ratio(mg[1], len, ng[1]);
    sv = q30_ratio(rad, len, 1'b0);
    top = (mg[0] > mg[2]) ? mg[0] : mg[2];
    if (top == 0) begin
      ch = 0;
      sh = -(64'sd1 << QB);
    end else begin
      b = bit_length(top);
      ax = mg[0] << (NORM_TOP - b);
      az = mg[2] << (NORM_TOP - b);
      rr = int_sqrt(ax * ax + az * az);
      ch = q30_ratio(az, rr, ng[2]);
      sh = q30_ratio(ax, rr, ng[0]);
    end
    rot.m[0] = round_out(ch, S1);
    rot.m[1] = round_out(sh * sv, SP);
    rot.m[2] = round_out(sh * cv, SP);
    rot.m[3] = '0;
    rot.m[4] = round_out(cv, S1);
    rot.m[5] = round_out(-sv, S1);
    rot.m[6] = round_out(-sh, S1);
    rot.m[7] = round_out(ch * sv, SP);
    rot.m[8] = round_out(ch * cv, SP);
    return rot;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic send_vector(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vx <= x;
    vy <= y;
    vz <= z;
    do @(posedge clk); while (in_stall);
    pending_rotations.push_back(rotation_of(x, y, z));
  endtask

  // Output side: drive stall and check every transfer.
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] got [9];
    rotation_t exp_rot;
    if (!rst && out_valid && !out_stall) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (pending_rotations.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_rot = pending_rotations.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_rot.m[i])
            report_mismatch($sformatf("r%0d%0d got %0d exp %0d", i / 3, i % 3,
                                      got[i], exp_rot.m[i]));
        if (zero_vector !== exp_rot.zero)
          report_mismatch($sformatf("zero_vector got %b exp %b", zero_vector, exp_rot.zero));
      end
    end
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_component();
    case ($urandom_range(5))
      0: return '0;
      1: return IN_W'($signed(16'($urandom)));
      2: return IN_W'($signed(4'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [IN_W-1:0] mx, mn;
    mx = {1'b0, {(IN_W-1){1'b1}}};
    mn = {1'b1, {(IN_W-1){1'b0}}};
    send_vector(0, 0, 0);
    send_vector(0, 32'h10000, 0);
    send_vector(0, -32'sh10000, 0);
    send_vector(0, mn, 0);
    send_vector(0, mx, 0);
    send_vector(32'h10000, 0, 0);
    send_vector(-32'sh10000, 0, 0);
    send_vector(0, 0, 32'h10000);
    send_vector(0, 0, -32'sh10000);
    send_vector(1, 0, 0);
    send_vector(0, 0, -1);
    send_vector(mx, mx, mx);
    send_vector(mn, mn, mn);
    send_vector(mn, mx, mn);
    send_vector(mx, 0, mn);
    send_vector(1, 1, 1);
    send_vector(-1, -1, -1);
    send_vector(1, mx, 0);
    send_vector(1, mn, -1);
    send_vector(32'h10000, 32'h10000, 0);
    send_vector(0, 0, 0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) send_vector(random_component(), random_component(), random_component());
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 300;
    test_random(150);
  endtask

  task automatic test_pause_until_drained();
    test_random(20);
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    test_random(20);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    send_idle_pct = 32;
    recv_idle_pct = 32;
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 32;
    recv_idle_pct = 32;
    recv_hold_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    vx = '0;
    vy = '0;
    vz = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_full_rate();
    test_pause_until_drained();
    test_random(390);
    in_valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("direction_to_rotation_matrix_top_test: PASS");
    else
      $display("direction_to_rotation_matrix_top_test: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("direction_to_rotation_matrix_top_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/dtrm_pkg.sv
hdl/dtrm_front.sv
hdl/dtrm_queue.sv
hdl/dtrm_sqrt.sv
hdl/dtrm_div.sv
hdl/dtrm_back.sv
hdl/direction_to_rotation_matrix_top.sv
tb/sv/direction_to_rotation_matrix_top_test.sv
